// ===== hw/rtl/all_pairs_shortest_path_defines.svh =====
// ----------------------------------------------------------------------------
// All-pairs shortest path assertion macros
// Shared property shorthands for the checker, sampled on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication.
`define APSP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("apsp_checker: property violated");

// Next-cycle implication.
`define APSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("apsp_checker: property violated");

`endif

// ===== hw/rtl/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// All-pairs shortest path package
// Widths, defaults, item codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apsp_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int DIST_WIDTH_DEF   = 24;
   localparam int OUT_DIST_W       = 24;
   localparam int KIND_W           = 2;
   localparam int VTX_W            = 6;
   localparam int WEIGHT_W         = 16;
   localparam int VCOUNT_W         = 7;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 7;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_EDGE    = 2'd1,
      KIND_COMPUTE = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERTEX_COUNT = 1'b0,
      CSR_DIRECTED     = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE2,
      ST_READ_WAIT,
      ST_ROW_ISSUE,
      ST_ROW_WAIT,
      ST_CELL_SUM,
      ST_CELL_WR,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/all_pairs_shortest_path.sv =====
// ----------------------------------------------------------------------------
// All-pairs shortest path store
// Distance store in one RAM, relaxed in place by one shared add/compare unit.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  kind, src, dst, weight
//  rsp      out        rsp_valid/rsp_ready  status, reachable, distance
//  csr      in         csr_we               csr_index, csr_wdata
//
//  An item is taken only in the idle state; one result beat per item.
//  Edge: one RAM write, a mirrored second write when undirected; read: registered RAM read.
//  Bad vertex: no RAM access. Clear: one RAM write per cycle over every entry.
//  Compute: per cell a sum state for registered read and sum, then a write state.
//  After reset a clearing pass over every entry runs before req_ready.
//  A stalled result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module all_pairs_shortest_path import apsp_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int DIST_WIDTH   = DIST_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [KIND_W-1:0]            req_kind,
   input  logic [VTX_W-1:0]             req_src,
   input  logic [VTX_W-1:0]             req_dst,
   input  logic signed [WEIGHT_W-1:0]   req_weight,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic                         rsp_reachable,
   output logic signed [OUT_DIST_W-1:0] rsp_distance,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int NW    = (CW > VCOUNT_W) ? CW : VCOUNT_W;
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = DIST_WIDTH + 1;
   localparam int XW    = (DIST_WIDTH > OUT_DIST_W) ? DIST_WIDTH : OUT_DIST_W;

   localparam logic [AW-1:0]          MAX_A   = AW'(MAX_VERTICES);
   localparam logic [NW-1:0]          MAX_N   = NW'(MAX_VERTICES);
   localparam logic [VW-1:0]          LAST_V  = VW'(MAX_VERTICES - 1);
   localparam logic signed [XW-1:0]   OUT_HI  = XW'((2 ** (OUT_DIST_W - 1)) - 1);
   localparam logic signed [XW-1:0]   OUT_LO  = -OUT_HI - XW'(1);

   function automatic logic [AW-1:0] vaddr(input logic [VW-1:0] r, input logic [VW-1:0] c);
      return AW'(r) * MAX_A + AW'(c);
   endfunction

   state_type state_ff, state_in;

   logic [VCOUNT_W-1:0]          vcount_ff, vcount_in;
   logic                         directed_ff, directed_in;
   logic [VW-1:0]                src_ff, src_in;
   logic [VW-1:0]                dst_ff, dst_in;
   logic signed [DIST_WIDTH-1:0] weight_ff, weight_in;
   logic [NW-1:0]                k_ff, k_in;
   logic [NW-1:0]                i_ff, i_in;
   logic [NW-1:0]                j_ff, j_in;
   logic [VW-1:0]                clr_row_ff, clr_row_in;
   logic [VW-1:0]                clr_col_ff, clr_col_in;
   logic                         clr_resp_ff, clr_resp_in;
   logic [EW-1:0]                ik_ff, ik_in;
   logic                         res_status_ff, res_status_in;
   logic                         res_reach_ff, res_reach_in;
   logic [OUT_DIST_W-1:0]        res_dist_ff, res_dist_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic                         rsp_reach_ff, rsp_reach_in;
   logic [OUT_DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [EW-1:0]                ram_wdata;
   logic [AW-1:0]                ram_raddr_a;
   logic [AW-1:0]                ram_raddr_b;
   logic [EW-1:0]                ram_rdata_a;
   logic [EW-1:0]                ram_rdata_b;

   logic                         alu_en;
   logic                         relax_upd;
   logic signed [DIST_WIDTH-1:0] relax_val;

   logic [NW-1:0]                n_act;
   logic                         req_bad;
   logic signed [DIST_WIDTH-1:0] req_w_ext;
   logic signed [DIST_WIDTH-1:0] rd_val;
   logic signed [XW-1:0]         rd_x;
   logic signed [XW-1:0]         rd_sat;
   logic [NW-1:0]                j_next;
   logic [NW-1:0]                i_next;
   logic [NW-1:0]                k_next;

   apsp_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_a (ram_rdata_a),
      .rd_data_b (ram_rdata_b)
   );

   apsp_alu #(
      .DIST_WIDTH (DIST_WIDTH)
   ) u_alu (
      .clock     (clock),
      .sum_en    (alu_en),
      .ik_val    (ik_ff[DIST_WIDTH-1:0]),
      .kj_entry  (ram_rdata_a),
      .ij_entry  (ram_rdata_b),
      .relax_upd (relax_upd),
      .relax_val (relax_val)
   );

   always_comb begin
      n_act     = (NW'(vcount_ff) > MAX_N) ? MAX_N : NW'(vcount_ff);
      req_bad   = (NW'(req_src) >= n_act) || (NW'(req_dst) >= n_act);
      req_w_ext = DIST_WIDTH'(req_weight);
      rd_val    = ram_rdata_a[DIST_WIDTH-1:0];
      rd_x      = XW'(rd_val);
      if (rd_x > OUT_HI) begin
         rd_sat = OUT_HI;
      end else if (rd_x < OUT_LO) begin
         rd_sat = OUT_LO;
      end else begin
         rd_sat = rd_x;
      end
      j_next = j_ff + NW'(1);
      i_next = i_ff + NW'(1);
      k_next = k_ff + NW'(1);
   end

   always_comb begin
      directed_in = directed_ff;
      vcount_in   = vcount_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VERTEX_COUNT: begin
               vcount_in = csr_wdata[VCOUNT_W-1:0];
            end
            CSR_DIRECTED: begin
               directed_in = csr_wdata[0];
            end
            default: begin
               vcount_in = vcount_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         vcount_ff    <= VCOUNT_RESET;
         directed_ff  <= 1'b0;
         clr_row_ff   <= '0;
         clr_col_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         directed_ff  <= directed_in;
         clr_row_ff   <= clr_row_in;
         clr_col_ff   <= clr_col_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      weight_ff     <= weight_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      ik_ff         <= ik_in;
      res_status_ff <= res_status_in;
      res_reach_ff  <= res_reach_in;
      res_dist_ff   <= res_dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      weight_in     = weight_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      clr_row_in    = clr_row_ff;
      clr_col_in    = clr_col_ff;
      clr_resp_in   = clr_resp_ff;
      ik_in         = ik_ff;
      res_status_in = res_status_ff;
      res_reach_in  = res_reach_ff;
      res_dist_in   = res_dist_ff;
      rsp_status_in = rsp_status_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = vaddr(i_ff[VW-1:0], j_ff[VW-1:0]);
      ram_wdata     = {1'b1, relax_val};
      ram_raddr_a   = vaddr(i_ff[VW-1:0], k_ff[VW-1:0]);
      ram_raddr_b   = vaddr(i_ff[VW-1:0], j_ff[VW-1:0]);
      alu_en        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = vaddr(clr_row_ff, clr_col_ff);
            ram_wdata  = {(clr_row_ff == clr_col_ff), {DIST_WIDTH{1'b0}}};
            clr_col_in = clr_col_ff + VW'(1);
            if (clr_col_ff == LAST_V) begin
               clr_col_in = '0;
               clr_row_in = clr_row_ff + VW'(1);
               if (clr_row_ff == LAST_V) begin
                  clr_row_in  = '0;
                  clr_resp_in = 1'b0;
                  state_in    = clr_resp_ff ? ST_RESP : ST_IDLE;
               end
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               src_in        = VW'(req_src);
               dst_in        = VW'(req_dst);
               weight_in     = req_w_ext;
               res_status_in = 1'b0;
               res_reach_in  = 1'b0;
               res_dist_in   = '0;
               case (kind_type'(req_kind))
                  KIND_CLEAR: begin
                     clr_row_in  = '0;
                     clr_col_in  = '0;
                     clr_resp_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  KIND_EDGE: begin
                     if (req_bad) begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = vaddr(VW'(req_src), VW'(req_dst));
                        ram_wdata = {1'b1, req_w_ext};
                        state_in  = directed_ff ? ST_RESP : ST_EDGE2;
                     end
                  end
                  KIND_COMPUTE: begin
                     k_in     = '0;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = (n_act == '0) ? ST_RESP : ST_ROW_ISSUE;
                  end
                  KIND_READ: begin
                     if (req_bad) begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end else begin
                        ram_raddr_a = vaddr(VW'(req_src), VW'(req_dst));
                        state_in    = ST_READ_WAIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EDGE2: begin
            ram_we    = 1'b1;
            ram_waddr = vaddr(dst_ff, src_ff);
            ram_wdata = {1'b1, weight_ff};
            state_in  = ST_RESP;
         end

         ST_READ_WAIT: begin
            if (ram_rdata_a[DIST_WIDTH]) begin
               res_reach_in = 1'b1;
               res_dist_in  = rd_sat[OUT_DIST_W-1:0];
            end
            state_in = ST_RESP;
         end

         ST_ROW_ISSUE: begin
            state_in = ST_ROW_WAIT;
         end

         ST_ROW_WAIT: begin
            ik_in = ram_rdata_a;
            if (ram_rdata_a[DIST_WIDTH]) begin
               ram_raddr_a = vaddr(k_ff[VW-1:0], j_ff[VW-1:0]);
               ram_raddr_b = vaddr(i_ff[VW-1:0], j_ff[VW-1:0]);
               state_in    = ST_CELL_SUM;
            end else begin
               j_in = '0;
               if (i_next < n_act) begin
                  i_in     = i_next;
                  state_in = ST_ROW_ISSUE;
               end else begin
                  i_in = '0;
                  if (k_next < n_act) begin
                     k_in     = k_next;
                     state_in = ST_ROW_ISSUE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end
         end

         ST_CELL_SUM: begin
            alu_en   = 1'b1;
            state_in = ST_CELL_WR;
         end

         ST_CELL_WR: begin
            if (relax_upd) begin
               ram_we = 1'b1;
               if (j_ff == k_ff) begin
                  ik_in = {1'b1, relax_val};
               end
            end
            if (j_next < n_act) begin
               j_in        = j_next;
               ram_raddr_a = vaddr(k_ff[VW-1:0], j_next[VW-1:0]);
               ram_raddr_b = vaddr(i_ff[VW-1:0], j_next[VW-1:0]);
               state_in    = ST_CELL_SUM;
            end else begin
               j_in = '0;
               if (i_next < n_act) begin
                  i_in     = i_next;
                  state_in = ST_ROW_ISSUE;
               end else begin
                  i_in = '0;
                  if (k_next < n_act) begin
                     k_in     = k_next;
                     state_in = ST_ROW_ISSUE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_reach_in  = res_reach_ff;
               rsp_dist_in   = res_dist_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_distance  = rsp_dist_ff;

endmodule

// ===== hw/rtl/apsp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apsp_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/apsp_alu.sv =====
// ----------------------------------------------------------------------------
// Relaxation unit
// Saturating add of the two path legs, registered, then compare with the entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apsp_alu import apsp_pkg::*; #(
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         sum_en,
   input  logic signed [DIST_WIDTH-1:0] ik_val,
   input  logic [DIST_WIDTH:0]          kj_entry,
   input  logic [DIST_WIDTH:0]          ij_entry,
   output logic                         relax_upd,
   output logic signed [DIST_WIDTH-1:0] relax_val
);

   localparam logic signed [DIST_WIDTH-1:0] DMAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
   localparam logic signed [DIST_WIDTH-1:0] DMIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

   logic signed [DIST_WIDTH:0]   wide_sum;
   logic signed [DIST_WIDTH-1:0] sat_sum;
   logic signed [DIST_WIDTH-1:0] sum_ff;
   logic                         kj_fin_ff;
   logic [DIST_WIDTH:0]          ij_ff;
   logic signed [DIST_WIDTH-1:0] ij_val;

   always_comb begin
      wide_sum = {ik_val[DIST_WIDTH-1], ik_val}
               + {kj_entry[DIST_WIDTH-1], kj_entry[DIST_WIDTH-1:0]};
      if (wide_sum[DIST_WIDTH] != wide_sum[DIST_WIDTH-1]) begin
         sat_sum = wide_sum[DIST_WIDTH] ? DMIN : DMAX;
      end else begin
         sat_sum = wide_sum[DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff    <= sat_sum;
         kj_fin_ff <= kj_entry[DIST_WIDTH];
         ij_ff     <= ij_entry;
      end
   end

   assign ij_val    = ij_ff[DIST_WIDTH-1:0];
   assign relax_val = sum_ff;
   assign relax_upd = kj_fin_ff && (!ij_ff[DIST_WIDTH] || (sum_ff < ij_val));

endmodule

// ===== hw/rtl/apsp_checker.sv =====
// ----------------------------------------------------------------------------
// All-pairs shortest path checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_defines.svh"

module apsp_checker import apsp_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic                         rsp_reachable,
   input logic signed [OUT_DIST_W-1:0] rsp_distance
);

   // Ready drops after every accepted item, as the block leaves the idle state.
   `APSP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // A stalled result beat holds its payload.
   `APSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_reachable) && $stable(rsp_distance))

   // An error result never reports a path.
   `APSP_ASSERT_IMP(a_err_unreach, rsp_valid && rsp_status, !rsp_reachable)

   // Without a path the distance reads as zero.
   `APSP_ASSERT_IMP(a_unreach_zero, rsp_valid && !rsp_reachable, rsp_distance == '0)

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);

// ===== verif/all_pairs_shortest_path_tb.sv =====
// ----------------------------------------------------------------------------
// All-pairs shortest path testbench
// Feeds clear, edge, compute and read beats with random idle gaps on both
// channels, predicts each result from a local copy of the distance store,
// and compares every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module all_pairs_shortest_path_tb import apsp_pkg::*; ();

   localparam int NV = MAX_VERTICES_DEF;
   localparam int unsigned STALL_LIMIT = 3 * NV * NV * (2 * NV + 2) + 20000;

   typedef struct packed {
      kind_type                    kind;
      logic [VTX_W-1:0]            src;
      logic [VTX_W-1:0]            dst;
      logic signed [WEIGHT_W-1:0]  weight;
   } path_request_type;

   typedef struct packed {
      logic                        status;
      logic                        reachable;
      logic signed [OUT_DIST_W-1:0] distance;
   } path_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [KIND_W-1:0] req_kind = '0;
   logic [VTX_W-1:0] req_src = '0;
   logic [VTX_W-1:0] req_dst = '0;
   logic signed [WEIGHT_W-1:0] req_weight = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_status;
   logic rsp_reachable;
   logic signed [OUT_DIST_W-1:0] rsp_distance;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int path_len [NV][NV];
   bit path_known [NV][NV];
   int unsigned vcount_cfg = 64;
   bit directed_cfg = 1'b0;

   path_request_type req_backlog [$];
   path_answer_type answers_due [$];
   path_request_type sent_req;
   int unsigned items_queued = 0;
   int unsigned answers_seen = 0;
   int unsigned failures = 0;
   int unsigned kind_seen [4] = '{0, 0, 0, 0};
   int unsigned tx_wait = 0;
   int unsigned rx_wait = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   int unsigned stall_cycles = 0;

   all_pairs_shortest_path u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_src       (req_src),
      .req_dst       (req_dst),
      .req_weight    (req_weight),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_reachable (rsp_reachable),
      .rsp_distance  (rsp_distance),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1ns clock = ~clock;

   function automatic longint clip_dist(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic void wipe_paths();
      for (int i = 0; i < NV; i++) begin
         for (int j = 0; j < NV; j++) begin
            path_len[i][j] = 0;
            path_known[i][j] = (i == j);
         end
      end
   endfunction

   function automatic path_answer_type resolve_request(path_request_type r);
      path_answer_type a;
      int unsigned n;
      longint s;
      a = '0;
      n = (vcount_cfg > NV) ? NV : vcount_cfg;
      case (r.kind)
         KIND_CLEAR: begin
            wipe_paths();
         end
         KIND_EDGE: begin
            if (r.src >= n || r.dst >= n) begin
               a.status = 1'b1;
            end else begin
               path_len[r.src][r.dst] = $signed(r.weight);
               path_known[r.src][r.dst] = 1'b1;
               if (!directed_cfg) begin
                  path_len[r.dst][r.src] = $signed(r.weight);
                  path_known[r.dst][r.src] = 1'b1;
               end
            end
         end
         KIND_COMPUTE: begin
            for (int k = 0; k < n; k++) begin
               for (int i = 0; i < n; i++) begin
                  if (path_known[i][k]) begin
                     for (int j = 0; j < n; j++) begin
                        if (path_known[k][j]) begin
                           s = clip_dist(longint'(path_len[i][k]) + longint'(path_len[k][j]),
                                         DIST_WIDTH_DEF);
                           if (!path_known[i][j] || s < longint'(path_len[i][j])) begin
                              path_len[i][j] = int'(s);
                              path_known[i][j] = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
         end
         default: begin
            if (r.src >= n || r.dst >= n) begin
               a.status = 1'b1;
            end else if (path_known[r.src][r.dst]) begin
               a.reachable = 1'b1;
               s = clip_dist(longint'(path_len[r.src][r.dst]), OUT_DIST_W);
               a.distance = s[OUT_DIST_W-1:0];
            end
         end
      endcase
      return a;
   endfunction

   function automatic int unsigned draw_idle(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic void note_field(string name, longint want, longint got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   task automatic queue_item(kind_type k, int unsigned s, int unsigned d, int w);
      path_request_type r;
      r.kind = k;
      r.src = s[VTX_W-1:0];
      r.dst = d[VTX_W-1:0];
      r.weight = w[WEIGHT_W-1:0];
      req_backlog = {req_backlog, r};
      items_queued++;
   endtask

   task automatic wait_quiet();
      while (answers_seen < items_queued) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_VERTEX_COUNT) vcount_cfg = value & 32'h7f;
      else directed_cfg = value[0];
   endtask

   task automatic random_phase(int unsigned count, int unsigned nv, bit dir, bit computes_ok);
      int unsigned span;
      int unsigned roll;
      int wt;
      wait_quiet();
      write_csr(CSR_VERTEX_COUNT, nv);
      write_csr(CSR_DIRECTED, dir);
      span = (nv == 0) ? 1 : ((nv > NV) ? NV : nv);
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: wt = $urandom_range(1, 1000);
            6, 7: wt = $urandom;
            8: wt = $urandom_range(0, 1) ? 32767 : -32768;
            default: wt = -int'($urandom_range(1, 50));
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 3)
            queue_item(KIND_CLEAR, $urandom, $urandom, $urandom);
         else if (roll < 11 && computes_ok)
            queue_item(KIND_COMPUTE, $urandom, $urandom, $urandom);
         else if (roll < 50)
            queue_item(KIND_EDGE, $urandom_range(0, span - 1), $urandom_range(0, span - 1), wt);
         else if (roll < 88)
            queue_item(KIND_READ, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                       $urandom);
         else
            queue_item(roll[0] ? KIND_EDGE : KIND_READ, $urandom_range(0, 63),
                       $urandom_range(0, 63), wt);
      end
   endtask

   // Request driver: the payload holds until the beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            answers_due = {answers_due, resolve_request(sent_req)};
            kind_seen[sent_req.kind]++;
         end
         if (!req_valid || req_ready) begin
            if (tx_wait > 0 || req_backlog.size() == 0) begin
               if (tx_wait > 0) tx_wait--;
               req_valid <= 1'b0;
            end else begin
               sent_req = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_kind <= sent_req.kind;
               req_src <= sent_req.src;
               req_dst <= sent_req.dst;
               req_weight <= sent_req.weight;
               tx_wait = draw_idle(tx_calm);
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      path_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
               failures++;
               $display("%0t: result beat with nothing outstanding, expected none, got %0d/%0d/%0d",
                        $time, rsp_status, rsp_reachable, rsp_distance);
            end else begin
               want = answers_due.pop_front();
               note_field("status", want.status, rsp_status);
               note_field("reachable", want.reachable, rsp_reachable);
               note_field("distance", $signed(want.distance), $signed(rsp_distance));
            end
            rx_wait = draw_idle(rx_calm);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, stall_cycles);
         $display("all_pairs_shortest_path regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wipe_paths();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 64 vertices, undirected.
      queue_item(KIND_READ, 0, 0, 0);
      queue_item(KIND_READ, 0, 1, 0);
      queue_item(KIND_READ, 63, 63, 0);
      queue_item(KIND_EDGE, 0, 63, 32767);
      queue_item(KIND_READ, 63, 0, 0);
      queue_item(KIND_EDGE, 5, 5, -32768);
      queue_item(KIND_READ, 5, 5, 0);
      queue_item(KIND_EDGE, 1, 2, 100);
      queue_item(KIND_EDGE, 1, 2, -7);
      queue_item(KIND_READ, 2, 1, 0);
      queue_item(KIND_EDGE, 10, 11, 0);
      queue_item(KIND_COMPUTE, 63, 63, -1);
      queue_item(KIND_READ, 1, 1, 0);
      queue_item(KIND_READ, 0, 63, 0);
      queue_item(KIND_READ, 5, 5, 0);
      queue_item(KIND_CLEAR, 0, 0, 0);
      queue_item(KIND_READ, 1, 2, 0);

      // A two-vertex negative cycle relaxed repeatedly runs into saturation.
      wait_quiet();
      write_csr(CSR_VERTEX_COUNT, 2);
      write_csr(CSR_DIRECTED, 1);
      queue_item(KIND_EDGE, 0, 1, -32768);
      queue_item(KIND_EDGE, 1, 0, -32768);
      repeat (5) queue_item(KIND_COMPUTE, 0, 0, 0);
      queue_item(KIND_READ, 0, 0, 0);
      queue_item(KIND_READ, 1, 0, 0);

      wait_quiet();
      write_csr(CSR_VERTEX_COUNT, 1);
      queue_item(KIND_EDGE, 0, 1, 5);
      queue_item(KIND_READ, 1, 0, 0);
      queue_item(KIND_READ, 0, 0, 0);

      random_phase(80, 4, 1'b0, 1'b1);
      random_phase(100, 8, 1'b1, 1'b1);
      random_phase(50, 2, 1'b1, 1'b1);
      random_phase(80, 64, 1'b0, 1'b0);
      random_phase(60, 16, 1'b1, 1'b1);
      random_phase(30, 1, 1'b0, 1'b1);
      random_phase(30, 127, 1'b1, 1'b0);
      random_phase(20, 0, 1'b0, 1'b1);
      random_phase(60, 6, 1'b0, 1'b1);

      wait_quiet();
      if (answers_due.size() != 0) begin
         failures += answers_due.size();
         $display("%0t: %0d results expected, got none", $time, answers_due.size());
      end
      $display("Checked %0d result beats: %0d clears, %0d edges, %0d computes, %0d reads.",
               answers_seen, kind_seen[KIND_CLEAR], kind_seen[KIND_EDGE],
               kind_seen[KIND_COMPUTE], kind_seen[KIND_READ]);
      $display("Vertex counts 0 to 127, both edge modes; %0d mismatches.", failures);
      if (failures == 0) begin
         $display("all_pairs_shortest_path regression: pass");
      end else begin
         $display("all_pairs_shortest_path regression: fail");
      end
      $finish;
   end

endmodule
